// File: sv/fkin_pkg.sv
// ----------------------------------------------------------------------------
// fkin_pkg
// Types, link constants, CORDIC tables and fixed-point helpers for the
// seven-joint forward kinematics pipeline.
// ----------------------------------------------------------------------------
package fkin_pkg;

  localparam int ANGLE_WIDTH        = 16;
  localparam int POSITION_FRAC_BITS = 16;
  localparam int CORDIC_STEPS       = 16;
  localparam int TAB_LEN            = 24;
  localparam int NUM_JOINTS         = 7;

  typedef logic signed [35:0] wide_t;
  typedef logic signed [30:0] ent_t;
  typedef ent_t mat_t [3][4];

  typedef struct packed {
    logic zero;
    ent_t c;
    ent_t s;
  } jcs_t;

  typedef jcs_t [NUM_JOINTS-1:0] jcs_arr_t;

  typedef struct packed {
    ent_t c;
    ent_t s;
  } cs_t;

  typedef struct packed {
    ent_t px;
    ent_t py;
    ent_t pz;
    ent_t r20;
  } carry_a_t;

  typedef struct packed {
    ent_t  px;
    ent_t  py;
    ent_t  pz;
    wide_t roll;
    wide_t yaw;
    logic  degen;
  } carry_b_t;

  localparam wide_t PI_Q30      = 36'sd3373259426;
  localparam wide_t HALF_PI_Q30 = 36'sd1686629713;
  localparam wide_t CORDIC_K    = 36'sh026DD3B6A;
  localparam wide_t SING_THRESH = 36'sd268;
  localparam ent_t  ONE_M       = 31'sd268435456;
  localparam ent_t  ENT_MAX     = 31'sh3FFFFFFF;
  localparam ent_t  ENT_MIN     = -31'sd1073741824;

  localparam wide_t ATAN_TAB [TAB_LEN] = '{
    36'sh03243F6A8, 36'sh01DAC6705, 36'sh00FADBAFC, 36'sh007F56EA6,
    36'sh003FEAB76, 36'sh001FFD55B, 36'sh000FFFAAA, 36'sh0007FFF55,
    36'sh0003FFFEA, 36'sh0001FFFFD, 36'sh0000FFFFF, 36'sh00007FFFF,
    36'sh00003FFFF, 36'sh00001FFFF, 36'sh00000FFFF, 36'sh000007FFF,
    36'sh000003FFF, 36'sh000001FFF, 36'sh000000FFF, 36'sh0000007FF,
    36'sh0000003FF, 36'sh0000001FF, 36'sh0000000FF, 36'sh00000007F
  };

  localparam ent_t LINK_T [NUM_JOINTS][3] = '{
    '{ 31'sd66929012, -31'sd40265318,  31'sd53405234},
    '{ 31'sd12012487,  31'sd31407,     31'sd22311550},
    '{ 31'sd78648904,  31'sd17416898, -31'sd1610613},
    '{ 31'sd42796665,  31'sd3634079,  -31'sd29259465},
    '{ 31'sd32091459, -31'sd2799782,  -31'sd15784005},
    '{-31'sd15435039,  31'sd15083120,  31'sd24159191},
    '{ 31'sd1736777,   31'sd343597,   -31'sd15314243}
  };

  localparam wide_t LINK_RZ [NUM_JOINTS] = '{
    36'sd0, -36'sd1686633657, 36'sd3373267314, 36'sd0, 36'sd0, 36'sd1686633657, 36'sd0
  };

  localparam wide_t LINK_RY [NUM_JOINTS] = '{
    36'sd0, 36'sd0, 36'sd0, 36'sd0, 36'sd1686633657, -36'sd1028859416, 36'sd1686633657
  };

  localparam wide_t LINK_RX [NUM_JOINTS] = '{
    36'sd0, 36'sd1686633657, -36'sd3373267314, -36'sd3373267314, 36'sd90945932,
    -36'sd1686633657, -36'sd210238649
  };

  localparam logic [NUM_JOINTS-1:0] NEG_JOINT = 7'b0011111;

  function automatic wide_t mul_q28(input ent_t a, input ent_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = (p + 64'sd134217728) >>> 28;
    return 36'(p);
  endfunction

  function automatic ent_t clamp_m(input logic signed [63:0] v);
    ent_t r;
    if (v > 64'(ENT_MAX)) begin
      r = ENT_MAX;
    end else if (v < 64'(ENT_MIN)) begin
      r = ENT_MIN;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  function automatic cs_t const_sincos(input wide_t a, input int steps);
    wide_t x;
    wide_t y;
    wide_t z;
    wide_t xs;
    wide_t ys;
    logic  flip;
    cs_t   r;
    x    = CORDIC_K;
    y    = '0;
    z    = a;
    flip = 1'b0;
    if (a > HALF_PI_Q30) begin
      z    = a - PI_Q30;
      flip = 1'b1;
    end else if (a < -HALF_PI_Q30) begin
      z    = a + PI_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < steps && i < TAB_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TAB[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TAB[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    r.c = 31'((x + 36'sd2) >>> 2);
    r.s = 31'((y + 36'sd2) >>> 2);
    return r;
  endfunction

endpackage

// File: sv/fkin_sincos.sv
// ----------------------------------------------------------------------------
// fkin_sincos
// Pipelined rotation-mode CORDIC lane: sine and cosine of one joint angle.
// ----------------------------------------------------------------------------
module fkin_sincos #(
  parameter int CordicSteps = fkin_pkg::CORDIC_STEPS
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  fkin_pkg::wide_t   angle_i,
  output fkin_pkg::jcs_t    cs_o
);

  fkin_pkg::wide_t x_q [CordicSteps+1];
  fkin_pkg::wide_t y_q [CordicSteps+1];
  fkin_pkg::wide_t z_q [CordicSteps+1];
  logic            flip_q [CordicSteps+1];
  logic            zero_q [CordicSteps+1];
  fkin_pkg::wide_t x_d [CordicSteps];
  fkin_pkg::wide_t y_d [CordicSteps];
  fkin_pkg::wide_t z_d [CordicSteps];
  fkin_pkg::wide_t xo;
  fkin_pkg::wide_t yo;
  fkin_pkg::jcs_t  cs_q;

  always_comb begin
    for (int i = 0; i < CordicSteps; i++) begin
      if (z_q[i] >= 0) begin
        x_d[i] = x_q[i] - (y_q[i] >>> i);
        y_d[i] = y_q[i] + (x_q[i] >>> i);
        z_d[i] = z_q[i] - fkin_pkg::ATAN_TAB[i];
      end else begin
        x_d[i] = x_q[i] + (y_q[i] >>> i);
        y_d[i] = y_q[i] - (x_q[i] >>> i);
        z_d[i] = z_q[i] + fkin_pkg::ATAN_TAB[i];
      end
    end
    xo = flip_q[CordicSteps] ? -x_q[CordicSteps] : x_q[CordicSteps];
    yo = flip_q[CordicSteps] ? -y_q[CordicSteps] : y_q[CordicSteps];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= fkin_pkg::CORDIC_K;
      y_q[0]    <= '0;
      zero_q[0] <= (angle_i == '0);
      if (angle_i > fkin_pkg::HALF_PI_Q30) begin
        z_q[0]    <= angle_i - fkin_pkg::PI_Q30;
        flip_q[0] <= 1'b1;
      end else if (angle_i < -fkin_pkg::HALF_PI_Q30) begin
        z_q[0]    <= angle_i + fkin_pkg::PI_Q30;
        flip_q[0] <= 1'b1;
      end else begin
        z_q[0]    <= angle_i;
        flip_q[0] <= 1'b0;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        x_q[i+1]    <= x_d[i];
        y_q[i+1]    <= y_d[i];
        z_q[i+1]    <= z_d[i];
        flip_q[i+1] <= flip_q[i];
        zero_q[i+1] <= zero_q[i];
      end
      cs_q.zero <= zero_q[CordicSteps];
      cs_q.c    <= 31'((xo + 36'sd2) >>> 2);
      cs_q.s    <= 31'((yo + 36'sd2) >>> 2);
    end
  end

  assign cs_o = cs_q;

endmodule

// File: sv/fkin_rot.sv
// ----------------------------------------------------------------------------
// fkin_rot
// Two-stage column rotation of the 3x4 transform: products, then sum/clamp.
// ----------------------------------------------------------------------------
module fkin_rot #(
  parameter int ColA = 0,
  parameter int ColB = 1
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  fkin_pkg::mat_t      m_i,
  input  fkin_pkg::ent_t      c_i,
  input  fkin_pkg::ent_t      s_i,
  input  logic                bypass_i,
  input  fkin_pkg::jcs_arr_t  jcs_i,
  output fkin_pkg::mat_t      m_o,
  output fkin_pkg::jcs_arr_t  jcs_o
);

  fkin_pkg::mat_t     m1_q;
  fkin_pkg::mat_t     m2_d;
  fkin_pkg::mat_t     m2_q;
  fkin_pkg::wide_t    pac_q [3];
  fkin_pkg::wide_t    pbs_q [3];
  fkin_pkg::wide_t    pbc_q [3];
  fkin_pkg::wide_t    pas_q [3];
  logic               byp1_q;
  fkin_pkg::jcs_arr_t jcs1_q;
  fkin_pkg::jcs_arr_t jcs2_q;

  always_comb begin
    m2_d = m1_q;
    if (!byp1_q) begin
      for (int r = 0; r < 3; r++) begin
        m2_d[r][ColA] = fkin_pkg::clamp_m(64'(pac_q[r]) + 64'(pbs_q[r]));
        m2_d[r][ColB] = fkin_pkg::clamp_m(64'(pbc_q[r]) - 64'(pas_q[r]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        pac_q[r] <= fkin_pkg::mul_q28(m_i[r][ColA], c_i);
        pbs_q[r] <= fkin_pkg::mul_q28(m_i[r][ColB], s_i);
        pbc_q[r] <= fkin_pkg::mul_q28(m_i[r][ColB], c_i);
        pas_q[r] <= fkin_pkg::mul_q28(m_i[r][ColA], s_i);
      end
      m1_q   <= m_i;
      byp1_q <= bypass_i;
      jcs1_q <= jcs_i;
      m2_q   <= m2_d;
      jcs2_q <= jcs1_q;
    end
  end

  assign m_o   = m2_q;
  assign jcs_o = jcs2_q;

endmodule

// File: sv/fkin_link.sv
// ----------------------------------------------------------------------------
// fkin_link
// One arm link: translation, fixed z/y/x rotations, then the joint rotation.
// ----------------------------------------------------------------------------
module fkin_link #(
  parameter int Link        = 0,
  parameter int CordicSteps = fkin_pkg::CORDIC_STEPS
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  fkin_pkg::mat_t      m_i,
  input  fkin_pkg::jcs_arr_t  jcs_i,
  output fkin_pkg::mat_t      m_o,
  output fkin_pkg::jcs_arr_t  jcs_o
);

  localparam fkin_pkg::cs_t RzCs = fkin_pkg::const_sincos(fkin_pkg::LINK_RZ[Link], CordicSteps);
  localparam fkin_pkg::cs_t RyCs = fkin_pkg::const_sincos(fkin_pkg::LINK_RY[Link], CordicSteps);
  localparam fkin_pkg::cs_t RxCs = fkin_pkg::const_sincos(fkin_pkg::LINK_RX[Link], CordicSteps);
  localparam logic RzByp = (fkin_pkg::LINK_RZ[Link] == '0);
  localparam logic RyByp = (fkin_pkg::LINK_RY[Link] == '0);
  localparam logic RxByp = (fkin_pkg::LINK_RX[Link] == '0);

  fkin_pkg::mat_t     m1_q;
  fkin_pkg::mat_t     m2_d;
  fkin_pkg::mat_t     m2_q;
  fkin_pkg::wide_t    pt_q [3][3];
  fkin_pkg::jcs_arr_t jcs1_q;
  fkin_pkg::jcs_arr_t jcs2_q;
  fkin_pkg::mat_t     m_rz;
  fkin_pkg::mat_t     m_ry;
  fkin_pkg::mat_t     m_rx;
  fkin_pkg::jcs_arr_t jcs_rz;
  fkin_pkg::jcs_arr_t jcs_ry;
  fkin_pkg::jcs_arr_t jcs_rx;

  always_comb begin
    m2_d = m1_q;
    for (int r = 0; r < 3; r++) begin
      m2_d[r][3] = fkin_pkg::clamp_m(64'(m1_q[r][3]) + 64'(pt_q[r][0])
                                     + 64'(pt_q[r][1]) + 64'(pt_q[r][2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          pt_q[r][k] <= fkin_pkg::mul_q28(m_i[r][k], fkin_pkg::LINK_T[Link][k]);
        end
      end
      m1_q   <= m_i;
      jcs1_q <= jcs_i;
      m2_q   <= m2_d;
      jcs2_q <= jcs1_q;
    end
  end

  fkin_rot #(.ColA(0), .ColB(1)) u_rot_z (
    .clk_i, .en_i, .m_i(m2_q), .c_i(RzCs.c), .s_i(RzCs.s), .bypass_i(RzByp),
    .jcs_i(jcs2_q), .m_o(m_rz), .jcs_o(jcs_rz)
  );

  fkin_rot #(.ColA(2), .ColB(0)) u_rot_y (
    .clk_i, .en_i, .m_i(m_rz), .c_i(RyCs.c), .s_i(RyCs.s), .bypass_i(RyByp),
    .jcs_i(jcs_rz), .m_o(m_ry), .jcs_o(jcs_ry)
  );

  fkin_rot #(.ColA(1), .ColB(2)) u_rot_x (
    .clk_i, .en_i, .m_i(m_ry), .c_i(RxCs.c), .s_i(RxCs.s), .bypass_i(RxByp),
    .jcs_i(jcs_ry), .m_o(m_rx), .jcs_o(jcs_rx)
  );

  fkin_rot #(.ColA(0), .ColB(1)) u_rot_q (
    .clk_i, .en_i, .m_i(m_rx), .c_i(jcs_rx[Link].c), .s_i(jcs_rx[Link].s),
    .bypass_i(jcs_rx[Link].zero), .jcs_i(jcs_rx), .m_o(m_o), .jcs_o(jcs_o)
  );

endmodule

// File: sv/fkin_vec.sv
// ----------------------------------------------------------------------------
// fkin_vec
// Pipelined vectoring CORDIC lane: atan2 angle and magnitude of (x, y).
// ----------------------------------------------------------------------------
module fkin_vec #(
  parameter int CordicSteps = fkin_pkg::CORDIC_STEPS
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  fkin_pkg::wide_t x_i,
  input  fkin_pkg::wide_t y_i,
  output fkin_pkg::wide_t angle_o,
  output fkin_pkg::wide_t mag_o
);

  fkin_pkg::wide_t    x_q [CordicSteps+1];
  fkin_pkg::wide_t    y_q [CordicSteps+1];
  fkin_pkg::wide_t    z_q [CordicSteps+1];
  logic               zero_q [CordicSteps+1];
  fkin_pkg::wide_t    x_d [CordicSteps];
  fkin_pkg::wide_t    y_d [CordicSteps];
  fkin_pkg::wide_t    z_d [CordicSteps];
  logic signed [71:0] prod;
  fkin_pkg::wide_t    angle_q;
  fkin_pkg::wide_t    mag_q;

  always_comb begin
    for (int i = 0; i < CordicSteps; i++) begin
      if (y_q[i] > 0) begin
        x_d[i] = x_q[i] + (y_q[i] >>> i);
        y_d[i] = y_q[i] - (x_q[i] >>> i);
        z_d[i] = z_q[i] + fkin_pkg::ATAN_TAB[i];
      end else begin
        x_d[i] = x_q[i] - (y_q[i] >>> i);
        y_d[i] = y_q[i] + (x_q[i] >>> i);
        z_d[i] = z_q[i] - fkin_pkg::ATAN_TAB[i];
      end
    end
    prod = 72'(x_q[CordicSteps]) * 72'(fkin_pkg::CORDIC_K);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= (y_i >= 0) ? fkin_pkg::PI_Q30 : -fkin_pkg::PI_Q30;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        x_q[i+1]    <= x_d[i];
        y_q[i+1]    <= y_d[i];
        z_q[i+1]    <= z_d[i];
        zero_q[i+1] <= zero_q[i];
      end
      if (zero_q[CordicSteps]) begin
        angle_q <= '0;
        mag_q   <= '0;
      end else begin
        angle_q <= z_q[CordicSteps];
        mag_q   <= 36'((prod + 72'sd536870912) >>> 30);
      end
    end
  end

  assign angle_o = angle_q;
  assign mag_o   = mag_q;

endmodule

// File: sv/arm_forward_kinematics_7dof_top.sv
// ----------------------------------------------------------------------------
// arm_forward_kinematics_7dof_top
// Seven-joint forward kinematics: joint angles in, tool position and
// roll/pitch/yaw out, fully pipelined.
//
//   channel  handshake               payload
//   input    in_valid_i / in_stall_o joint_angle_0_i .. joint_angle_6_i
//   output   out_valid_o/ out_stall_i tool_x/y/z_o, tool_roll/pitch/yaw_o,
//                                     gimbal_degenerate_o
//
// One item per cycle while the output is not stalled; the pipeline is seven
// sine/cosine lanes, seven 10-stage links, two vectoring passes, output reg.
// Reset clears only the valid line.
// A stalled output freezes the whole pipeline and raises in_stall_o.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_7dof_top #(
  parameter int AngleWidth       = fkin_pkg::ANGLE_WIDTH,
  parameter int PositionFracBits = fkin_pkg::POSITION_FRAC_BITS,
  parameter int CordicSteps      = fkin_pkg::CORDIC_STEPS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [AngleWidth-1:0]       joint_angle_0_i,
  input  logic signed [AngleWidth-1:0]       joint_angle_1_i,
  input  logic signed [AngleWidth-1:0]       joint_angle_2_i,
  input  logic signed [AngleWidth-1:0]       joint_angle_3_i,
  input  logic signed [AngleWidth-1:0]       joint_angle_4_i,
  input  logic signed [AngleWidth-1:0]       joint_angle_5_i,
  input  logic signed [AngleWidth-1:0]       joint_angle_6_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [PositionFracBits+4:0] tool_x_o,
  output logic signed [PositionFracBits+4:0] tool_y_o,
  output logic signed [PositionFracBits+4:0] tool_z_o,
  output logic signed [AngleWidth-1:0]       tool_roll_o,
  output logic signed [AngleWidth-1:0]       tool_pitch_o,
  output logic signed [AngleWidth-1:0]       tool_yaw_o,
  output logic                               gimbal_degenerate_o
);

  localparam int VecLat   = CordicSteps + 2;
  localparam int Latency  = 3 * VecLat + 7 * 10 + 1;
  localparam int AngShift = 33 - AngleWidth;
  localparam int PosShift = 28 - PositionFracBits;
  localparam fkin_pkg::wide_t AngMax = (36'sd1 <<< (AngleWidth - 1)) - 36'sd1;
  localparam fkin_pkg::wide_t AngMin = -(36'sd1 <<< (AngleWidth - 1));
  localparam fkin_pkg::wide_t PosMax = (36'sd1 <<< (PositionFracBits + 4)) - 36'sd1;
  localparam fkin_pkg::wide_t PosMin = -(36'sd1 <<< (PositionFracBits + 4));

  function automatic logic signed [AngleWidth-1:0] out_angle(input fkin_pkg::wide_t z);
    fkin_pkg::wide_t r;
    r = (z + (36'sd1 <<< (AngShift - 1))) >>> AngShift;
    if (r > AngMax) begin
      r = AngMax;
    end else if (r < AngMin) begin
      r = AngMin;
    end
    return r[AngleWidth-1:0];
  endfunction

  function automatic logic signed [PositionFracBits+4:0] out_pos(input fkin_pkg::ent_t v);
    fkin_pkg::wide_t r;
    r = (36'(v) + (36'sd1 <<< (PosShift - 1))) >>> PosShift;
    if (r > PosMax) begin
      r = PosMax;
    end else if (r < PosMin) begin
      r = PosMin;
    end
    return r[PositionFracBits+4:0];
  endfunction

  logic                         en;
  logic [Latency-1:0]           vld_q;
  logic signed [AngleWidth-1:0] ja [7];
  fkin_pkg::wide_t              ang [7];
  fkin_pkg::jcs_arr_t           jcs0;
  fkin_pkg::mat_t               m_ch [8];
  fkin_pkg::jcs_arr_t           jcs_ch [7];
  fkin_pkg::wide_t              yaw_a;
  fkin_pkg::wide_t              sy_a;
  fkin_pkg::wide_t              roll_n;
  fkin_pkg::wide_t              roll_d;
  fkin_pkg::wide_t              pitch_b;
  fkin_pkg::wide_t              pitch_y;
  logic                         degen;
  fkin_pkg::carry_a_t           ca_d;
  fkin_pkg::carry_a_t           ca_q [VecLat];
  fkin_pkg::carry_b_t           cb_d;
  fkin_pkg::carry_b_t           cb_q [VecLat];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = out_valid_o && out_stall_i;

  assign ja[0] = joint_angle_0_i;
  assign ja[1] = joint_angle_1_i;
  assign ja[2] = joint_angle_2_i;
  assign ja[3] = joint_angle_3_i;
  assign ja[4] = joint_angle_4_i;
  assign ja[5] = joint_angle_5_i;
  assign ja[6] = joint_angle_6_i;

  for (genvar j = 0; j < 7; j++) begin : g_lane
    fkin_pkg::wide_t q;
    assign q      = 36'(ja[j]) <<< AngShift;
    assign ang[j] = fkin_pkg::NEG_JOINT[j] ? -q : q;

    fkin_sincos #(.CordicSteps(CordicSteps)) u_sincos (
      .clk_i, .en_i(en), .angle_i(ang[j]), .cs_o(jcs0[j])
    );
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        m_ch[0][r][c] = (r == c) ? fkin_pkg::ONE_M : '0;
      end
    end
  end

  assign jcs_ch[0] = jcs0;

  for (genvar j = 0; j < 7; j++) begin : g_link
    if (j < 6) begin : g_mid
      fkin_link #(.Link(j), .CordicSteps(CordicSteps)) u_link (
        .clk_i, .en_i(en), .m_i(m_ch[j]), .jcs_i(jcs_ch[j]),
        .m_o(m_ch[j+1]), .jcs_o(jcs_ch[j+1])
      );
    end else begin : g_last
      fkin_link #(.Link(j), .CordicSteps(CordicSteps)) u_link (
        .clk_i, .en_i(en), .m_i(m_ch[j]), .jcs_i(jcs_ch[j]),
        .m_o(m_ch[j+1]), .jcs_o()
      );
    end
  end

  fkin_vec #(.CordicSteps(CordicSteps)) u_vec_yaw (
    .clk_i, .en_i(en), .x_i(36'(m_ch[7][0][0])), .y_i(36'(m_ch[7][1][0])),
    .angle_o(yaw_a), .mag_o(sy_a)
  );

  fkin_vec #(.CordicSteps(CordicSteps)) u_vec_roll (
    .clk_i, .en_i(en), .x_i(36'(m_ch[7][2][2])), .y_i(36'(m_ch[7][2][1])),
    .angle_o(roll_n), .mag_o()
  );

  fkin_vec #(.CordicSteps(CordicSteps)) u_vec_roll_dg (
    .clk_i, .en_i(en), .x_i(36'(m_ch[7][1][1])), .y_i(-36'(m_ch[7][1][2])),
    .angle_o(roll_d), .mag_o()
  );

  assign ca_d.px  = m_ch[7][0][3];
  assign ca_d.py  = m_ch[7][1][3];
  assign ca_d.pz  = m_ch[7][2][3];
  assign ca_d.r20 = m_ch[7][2][0];

  assign degen   = (sy_a <= fkin_pkg::SING_THRESH);
  assign pitch_y = degen ? 36'(ca_q[VecLat-1].r20) : -36'(ca_q[VecLat-1].r20);

  fkin_vec #(.CordicSteps(CordicSteps)) u_vec_pitch (
    .clk_i, .en_i(en), .x_i(sy_a), .y_i(pitch_y), .angle_o(pitch_b), .mag_o()
  );

  assign cb_d.px    = ca_q[VecLat-1].px;
  assign cb_d.py    = ca_q[VecLat-1].py;
  assign cb_d.pz    = ca_q[VecLat-1].pz;
  assign cb_d.roll  = degen ? roll_d : roll_n;
  assign cb_d.yaw   = degen ? '0 : yaw_a;
  assign cb_d.degen = degen;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ca_q[0] <= ca_d;
      cb_q[0] <= cb_d;
      for (int i = 1; i < VecLat; i++) begin
        ca_q[i] <= ca_q[i-1];
        cb_q[i] <= cb_q[i-1];
      end
      tool_x_o            <= out_pos(cb_q[VecLat-1].px);
      tool_y_o            <= out_pos(cb_q[VecLat-1].py);
      tool_z_o            <= out_pos(cb_q[VecLat-1].pz);
      tool_roll_o         <= out_angle(cb_q[VecLat-1].roll);
      tool_pitch_o        <= out_angle(pitch_b);
      tool_yaw_o          <= out_angle(cb_q[VecLat-1].yaw);
      gimbal_degenerate_o <= cb_q[VecLat-1].degen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Latency-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[Latency-1];

endmodule

// File: sv/fkin_chk.sv
// ----------------------------------------------------------------------------
// fkin_chk
// Port-level checks for the forward kinematics block, bound to the top level.
// ----------------------------------------------------------------------------
module fkin_chk #(
  parameter int AngleWidth       = fkin_pkg::ANGLE_WIDTH,
  parameter int PositionFracBits = fkin_pkg::POSITION_FRAC_BITS
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [PositionFracBits+4:0] tool_x_o,
  input logic signed [AngleWidth-1:0]       tool_yaw_o,
  input logic                               gimbal_degenerate_o
);

  a_stall_holds_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped during stall");

  a_stall_holds_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(tool_x_o) && $stable(tool_yaw_o))
    else $error("output payload changed during stall");

  a_in_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to output backpressure");

  a_degen_yaw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gimbal_degenerate_o |-> tool_yaw_o == '0)
    else $error("yaw nonzero on degenerate transfer");

endmodule

bind arm_forward_kinematics_7dof_top fkin_chk #(
  .AngleWidth(AngleWidth),
  .PositionFracBits(PositionFracBits)
) u_fkin_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .tool_x_o(tool_x_o),
  .tool_yaw_o(tool_yaw_o),
  .gimbal_degenerate_o(gimbal_degenerate_o)
);

// File: bench/tb_arm_forward_kinematics_7dof_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arm_forward_kinematics_7dof_top
// Streams joint-angle sets through the kinematics pipeline and compares every
// pose with a bit-exact fixed-point model of the link chain and the CORDIC
// math. Both sides idle in random bursts. The receiver holds off long enough
// to back the pipeline up, and the sender drains the pipeline once midway.
// ----------------------------------------------------------------------------
module tb_arm_forward_kinematics_7dof_top;

  localparam int AW  = fkin_pkg::ANGLE_WIDTH;
  localparam int PW  = fkin_pkg::POSITION_FRAC_BITS + 5;
  localparam int NJ  = fkin_pkg::NUM_JOINTS;
  localparam int NUM_ITEMS = 700;
  localparam int LATENCY   = 3 * (fkin_pkg::CORDIC_STEPS + 2) + 71;

  localparam longint K_GAIN  = 64'sh26DD3B6A;
  localparam longint PI_Q    = 64'sd3373259426;
  localparam longint HPI_Q   = 64'sd1686629713;
  localparam longint ENT_HI  = (64'sd1 <<< 30) - 1;
  localparam longint ENT_LO  = -(64'sd1 <<< 30);
  localparam longint DEG_LIM = 64'sd268;

  typedef struct {
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [PW-1:0] z;
    logic [AW-1:0] roll;
    logic [AW-1:0] pitch;
    logic [AW-1:0] yaw;
    logic          degen;
  } pose_t;

  typedef logic signed [AW-1:0] joints_t [NJ];

  class pose_scoreboard;
    pose_t  pending[$];
    int     errors;
    int     checked;
    int     degen_seen;
    longint frame [3][4];
    longint tr [7][3];
    longint rz [7];
    longint ry [7];
    longint rx [7];
    longint atab [16];

    function new();
      tr = '{'{66929012, -40265318, 53405234}, '{12012487, 31407, 22311550},
             '{78648904, 17416898, -1610613}, '{42796665, 3634079, -29259465},
             '{32091459, -2799782, -15784005}, '{-15435039, 15083120, 24159191},
             '{1736777, 343597, -15314243}};
      rz = '{0, -1686633657, 64'sd3373267314, 0, 0, 1686633657, 0};
      ry = '{0, 0, 0, 0, 1686633657, -1028859416, 1686633657};
      rx = '{0, 1686633657, -64'sd3373267314, -64'sd3373267314, 90945932,
             -1686633657, -210238649};
      atab = '{'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76,
               'h01FFD55B, 'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD,
               'h000FFFFF, 'h0007FFFF, 'h0003FFFF, 'h0001FFFF, 'h0000FFFF,
               'h00007FFF};
      errors = 0;
      checked = 0;
      degen_seen = 0;
    endfunction

    function longint mul28(longint a, longint b);
      return (a * b + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function longint clamp_entry(longint v);
      if (v > ENT_HI) return ENT_HI;
      if (v < ENT_LO) return ENT_LO;
      return v;
    endfunction

    function void sin_cos(longint ang, output longint c, output longint s);
      longint x, y, z, xs, ys;
      bit flip;
      x = K_GAIN;
      y = 0;
      flip = 0;
      if (ang > HPI_Q) begin
        ang = ang - PI_Q;
        flip = 1;
      end else if (ang < -HPI_Q) begin
        ang = ang + PI_Q;
        flip = 1;
      end
      z = ang;
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - atab[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + atab[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = (x + 2) >>> 2;
      s = (y + 2) >>> 2;
    endfunction

    function longint vec_angle(longint y, longint x, output longint mag);
      longint z, xs, ys;
      z = 0;
      mag = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? PI_Q : -PI_Q;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atab[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atab[i];
        end
      end
      mag = (x * K_GAIN + (64'sd1 <<< 29)) >>> 30;
      return z;
    endfunction

    function void turn(int a, int b, longint ang);
      longint c, s, pa, pb;
      if (ang == 0) return;
      sin_cos(ang, c, s);
      for (int r = 0; r < 3; r++) begin
        pa = frame[r][a];
        pb = frame[r][b];
        frame[r][a] = clamp_entry(mul28(pa, c) + mul28(pb, s));
        frame[r][b] = clamp_entry(mul28(pb, c) - mul28(pa, s));
      end
    endfunction

    function logic [PW-1:0] to_pos(longint v);
      longint r;
      r = (v + (64'sd1 <<< 11)) >>> 12;
      if (r > (64'sd1 <<< 20) - 1) r = (64'sd1 <<< 20) - 1;
      if (r < -(64'sd1 <<< 20)) r = -(64'sd1 <<< 20);
      return r[PW-1:0];
    endfunction

    function logic [AW-1:0] to_angle(longint v);
      longint r;
      r = (v + (64'sd1 <<< 16)) >>> 17;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[AW-1:0];
    endfunction

    function void note_joints(joints_t q);
      pose_t  p;
      longint qa, norm, dummy, roll, pitch, yaw;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          frame[r][c] = (r == c) ? (64'sd1 <<< 28) : 0;
        end
      end
      for (int j = 0; j < NJ; j++) begin
        qa = longint'(q[j]) * (64'sd1 <<< 17);
        if (j < 5) qa = -qa;
        for (int r = 0; r < 3; r++) begin
          frame[r][3] = clamp_entry(frame[r][3] + mul28(frame[r][0], tr[j][0])
                                    + mul28(frame[r][1], tr[j][1])
                                    + mul28(frame[r][2], tr[j][2]));
        end
        turn(0, 1, rz[j]);
        turn(2, 0, ry[j]);
        turn(1, 2, rx[j]);
        turn(0, 1, qa);
      end
      yaw = vec_angle(frame[1][0], frame[0][0], norm);
      p.degen = (norm <= DEG_LIM);
      if (!p.degen) begin
        roll  = vec_angle(frame[2][1], frame[2][2], dummy);
        pitch = vec_angle(-frame[2][0], norm, dummy);
      end else begin
        roll  = vec_angle(-frame[1][2], frame[1][1], dummy);
        pitch = vec_angle(frame[2][0], norm, dummy);
        yaw   = 0;
      end
      p.x = to_pos(frame[0][3]);
      p.y = to_pos(frame[1][3]);
      p.z = to_pos(frame[2][3]);
      p.roll  = to_angle(roll);
      p.pitch = to_angle(pitch);
      p.yaw   = to_angle(yaw);
      pending.push_back(p);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on pose %0d: %s got %h expected %h", checked, what, got, want);
      errors++;
    endtask

    task check_pose(pose_t got);
      pose_t want;
      if (pending.size() == 0) begin
        report("unexpected transfer", 0, 0);
      end else begin
        want = pending.pop_front();
        if (got.x !== want.x) report("tool_x", 32'(got.x), 32'(want.x));
        if (got.y !== want.y) report("tool_y", 32'(got.y), 32'(want.y));
        if (got.z !== want.z) report("tool_z", 32'(got.z), 32'(want.z));
        if (got.roll !== want.roll) report("tool_roll", 32'(got.roll), 32'(want.roll));
        if (got.pitch !== want.pitch) begin
          report("tool_pitch", 32'(got.pitch), 32'(want.pitch));
        end
        if (got.yaw !== want.yaw) report("tool_yaw", 32'(got.yaw), 32'(want.yaw));
        if (got.degen !== want.degen) begin
          report("gimbal_degenerate", 32'(got.degen), 32'(want.degen));
        end
        if (got.degen === 1'b1) degen_seen++;
      end
      checked++;
    endtask
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [AW-1:0] ja [NJ];
  logic [PW-1:0] tool_x_o, tool_y_o, tool_z_o;
  logic [AW-1:0] tool_roll_o, tool_pitch_o, tool_yaw_o;
  logic          gimbal_degenerate_o;

  pose_scoreboard board;
  bit             receiver_quiet;
  int             sent;

  arm_forward_kinematics_7dof_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .joint_angle_0_i    (ja[0]),
    .joint_angle_1_i    (ja[1]),
    .joint_angle_2_i    (ja[2]),
    .joint_angle_3_i    (ja[3]),
    .joint_angle_4_i    (ja[4]),
    .joint_angle_5_i    (ja[5]),
    .joint_angle_6_i    (ja[6]),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .tool_x_o           (tool_x_o),
    .tool_y_o           (tool_y_o),
    .tool_z_o           (tool_z_o),
    .tool_roll_o        (tool_roll_o),
    .tool_pitch_o       (tool_pitch_o),
    .tool_yaw_o         (tool_yaw_o),
    .gimbal_degenerate_o(gimbal_degenerate_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("timeout with %0d poses outstanding", board.pending.size());
    $display("simulation failed");
    $finish;
  end

  task automatic make_joints(int idx, output joints_t q);
    int pick;
    for (int j = 0; j < NJ; j++) begin
      q[j] = AW'($urandom);
    end
    if (idx < 25) begin
      pick = idx % 5;
      for (int j = 0; j < NJ; j++) begin
        case (pick)
          0: q[j] = '0;
          1: q[j] = 16'sh7FFF;
          2: q[j] = 16'sh8000;
          3: q[j] = (j == idx / 5 + 2) ? 16'sd12868 : 16'sd0;
          default: q[j] = (j == idx / 5) ? -16'sd12868 : 16'sd0;
        endcase
      end
    end else if ($urandom_range(0, 3) == 0) begin
      for (int j = 0; j < NJ; j++) begin
        q[j] = $signed(16'($urandom_range(0, 800))) - 16'sd400;
      end
    end
  endtask

  // send one pose query and hold it until the transfer
  task automatic send_item(joints_t q, bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int j = 0; j < NJ; j++) ja[j] <= q[j];
    do @(posedge clk_i); while (in_stall_o);
    board.note_joints(q);
    sent++;
  endtask

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    pose_t got;
    int    hold;
    bit    long_done;
    hold = 0;
    long_done = 0;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.x = tool_x_o;
        got.y = tool_y_o;
        got.z = tool_z_o;
        got.roll = tool_roll_o;
        got.pitch = tool_pitch_o;
        got.yaw = tool_yaw_o;
        got.degen = gimbal_degenerate_o;
        board.check_pose(got);
      end
      if (!long_done && board.checked >= 320) begin
        long_done = 1;
        hold = 400;
      end else if (hold == 0 && !receiver_quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 17);
      end
      if (receiver_quiet && long_done) hold = 0;
      out_stall_i <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  initial begin
    joints_t q;
    int      waited;
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    receiver_quiet = 0;
    sent = 0;
    for (int j = 0; j < NJ; j++) ja[j] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NUM_ITEMS; i++) begin
      if (i == 450) begin
        // drain the pipeline before going on
        in_valid_i <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk_i);
      end
      if (i == 600) receiver_quiet = 1;
      make_joints(i, q);
      send_item(q, i >= 25 && !(i >= 300 && i < 450) && i < 600);
    end
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < LATENCY + 20) begin
      @(posedge clk_i);
      waited++;
    end
    $display("%0d pose queries sent, %0d checked, %0d on the gimbal-lock branch",
             sent, board.checked, board.degen_seen);
    $display("covered joint extremes, single-joint quarter turns, backpressure and drain");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/fkin_pkg.sv
sv/fkin_sincos.sv
sv/fkin_rot.sv
sv/fkin_link.sv
sv/fkin_vec.sv
sv/arm_forward_kinematics_7dof_top.sv
sv/fkin_chk.sv
bench/tb_arm_forward_kinematics_7dof_top.sv
